// ----- design/utf8_path_hash_top_macros.svh -----
// ----------------------------------------------------------------------------
// utf8_path_hash_top_macros: assertion macros
// Shared assertion forms used by the path hash block. All of them are clocked
// on clk and switched off while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef UTF8_PATH_HASH_TOP_MACROS_SVH
`define UTF8_PATH_HASH_TOP_MACROS_SVH

// Same-cycle implication.
`define UPH_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define UPH_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/uph_pkg.sv -----
// ----------------------------------------------------------------------------
// uph_pkg: shared types and helpers of the UTF-8 path hash
// Decoder state, step result and the fold and rotate-add helpers.
// ----------------------------------------------------------------------------
package uph_pkg;

	localparam int HashWidth    = 32;
	localparam int PartialWidth = 18;
	localparam int RotBits      = 7;

	localparam logic [7:0] LeadTwoLo   = 8'hC2;
	localparam logic [7:0] LeadTwoHi   = 8'hDF;
	localparam logic [7:0] LeadThreeLo = 8'hE0;
	localparam logic [7:0] LeadThreeHi = 8'hEF;
	localparam logic [7:0] LeadFour    = 8'hF0;
	localparam logic [7:0] ContMask    = 8'hC0;
	localparam logic [7:0] ContTag     = 8'h80;

	localparam logic [HashWidth-1:0] BadPoint  = 32'hFFFF_FFFF;
	localparam logic [HashWidth-1:0] LowerA    = 32'h61;
	localparam logic [HashWidth-1:0] LowerZ    = 32'h7A;
	localparam logic [HashWidth-1:0] CaseShift = 32'h20;
	localparam logic [HashWidth-1:0] BackSlash = 32'h5C;
	localparam logic [HashWidth-1:0] Slash     = 32'h2F;

	typedef struct packed {
		logic [HashWidth-1:0]    hash;
		logic [PartialWidth-1:0] partial;
		logic [1:0]              needed;
		logic [1:0]              seen;
	} uph_state_t;

	typedef struct packed {
		logic                 emit;
		logic [HashWidth-1:0] hash;
	} uph_result_t;

	function automatic logic [HashWidth-1:0] fold_point(input logic [HashWidth-1:0] p);
		logic [HashWidth-1:0] r;
		r = p;
		if (p >= LowerA && p <= LowerZ) begin
			r = p - CaseShift;
		end else if (p == BackSlash) begin
			r = Slash;
		end
		return r;
	endfunction

	function automatic logic [HashWidth-1:0] absorb(input logic [HashWidth-1:0] h,
			input logic [HashWidth-1:0] p);
		logic [HashWidth-1:0] rot;
		rot = (h << RotBits) | (h >> (HashWidth - RotBits));
		return rot + fold_point(p);
	endfunction

endpackage

// ----- design/utf8_path_hash_top.sv -----
// ----------------------------------------------------------------------------
// utf8_path_hash_top: streaming hash of zero-terminated UTF-8 paths
// Decodes a byte stream into code points, folds case and slashes, and emits
// the rotate-add hash of each path when its terminating zero arrives.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid, in_stall, data_byte) moves one path byte per
// word. The output channel (out_valid, out_stall, digest) moves one hash
// per word, one for every code point of zero (a plain zero byte, a zero byte
// that breaks a pending sequence, or an overlong zero).
// A byte accepted by the input register is decoded and folded into the
// running hash when it leaves that register, which waits while a hash is
// held up in the result register; a hash it produces is registered there
// and drives the output from then on.
// Throughput is one byte per cycle while the receiver does not stall. The
// critical path is the decoder plus up to four chained 32-bit rotate-add
// updates, which a broken sequence followed by a plain byte or bad lead requires.
// When the receiver stalls with a hash waiting, the input register still
// takes one more byte; the stall then reaches in_stall until the hash drains.
// Reset clears the running hash and the pending sequence and empties both
// registers, so the first byte after reset starts a new path.
// ----------------------------------------------------------------------------
`include "utf8_path_hash_top_macros.svh"

module utf8_path_hash_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] digest
);

	// Input register stage.
	logic       valid_s1;
	logic [7:0] byte_s1;

	// Decoder state and result register.
	uph_pkg::uph_state_t  state_q;
	uph_pkg::uph_state_t  state_next;
	uph_pkg::uph_result_t step_res;
	logic                 out_valid_q;
	logic [31:0]          digest_q;

	logic out_blocked;
	logic advance;

	// The registered byte can retire whenever the result slot is free or is
	// being taken in this cycle.
	assign out_blocked = out_valid_q && out_stall;
	assign advance     = valid_s1 && !out_blocked;
	assign in_stall    = valid_s1 && out_blocked;

	uph_step u_step (
		.cur_state  (state_q),
		.data_byte  (byte_s1),
		.next_state (state_next),
		.result     (step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= data_byte;
		end
	end

	// The decoder state is control state: it must start clean on every reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && step_res.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && step_res.emit) begin
			digest_q <= step_res.hash;
		end
	end

	assign out_valid = out_valid_q;
	assign digest    = digest_q;

	// A pending sequence never has as many continuation bytes as it needs.
	`UPH_ASSERT_NOW(a_seen_below_needed, state_q.needed != 2'd0, state_q.seen < state_q.needed, "continuation count reached the sequence length")
	// With no sequence pending, the gathered bits and count are clear.
	`UPH_ASSERT_NOW(a_idle_clean, state_q.needed == 2'd0, state_q.seen == 2'd0 && state_q.partial == '0, "stale sequence state with no lead pending")
	// An emitted hash lands in the result register and restarts the hash.
	`UPH_ASSERT_NEXT(a_emit_lands, advance && step_res.emit, out_valid_q && digest_q == $past(step_res.hash) && state_q.hash == '0, "terminator did not publish and clear the hash")
	// The input side is held off only while a word waits in the input register.
	`UPH_ASSERT_NOW(a_stall_needs_item, in_stall, valid_s1 && out_valid_q, "input stalled with nothing to hold it up")

endmodule

// ----- design/uph_step.sv -----
// ----------------------------------------------------------------------------
// uph_step: one-byte decode and hash update
// Combinational next-state logic: continuation handling, broken-sequence
// recovery, lead decode, folding and the rotate-add updates.
// ----------------------------------------------------------------------------
module uph_step (
	input  uph_pkg::uph_state_t  cur_state,
	input  logic [7:0]           data_byte,
	output uph_pkg::uph_state_t  next_state,
	output uph_pkg::uph_result_t result
);

	logic                              is_cont;
	logic                              take_lead;
	logic [1:0]                        seen_inc;
	logic [uph_pkg::PartialWidth-1:0]  grown;
	logic [uph_pkg::HashWidth-1:0]     h;
	logic [uph_pkg::HashWidth-1:0]     byte_point;

	assign is_cont    = (data_byte & uph_pkg::ContMask) == uph_pkg::ContTag;
	assign seen_inc   = cur_state.seen + 2'd1;
	assign grown      = {cur_state.partial[uph_pkg::PartialWidth-7:0], data_byte[5:0]};
	assign byte_point = {{(uph_pkg::HashWidth-8){1'b0}}, data_byte};

	always_comb begin
		next_state  = cur_state;
		result.emit = 1'b0;
		result.hash = cur_state.hash;
		h           = cur_state.hash;
		take_lead   = 1'b1;

		if (cur_state.needed != 2'd0) begin
			if (is_cont) begin
				take_lead = 1'b0;
				if (seen_inc >= cur_state.needed) begin
					next_state.needed  = 2'd0;
					next_state.seen    = 2'd0;
					next_state.partial = '0;
					if (grown == '0) begin
						result.emit     = 1'b1;
						result.hash     = h;
						next_state.hash = '0;
					end else begin
						next_state.hash = uph_pkg::absorb(h,
							{{(uph_pkg::HashWidth-uph_pkg::PartialWidth){1'b0}}, grown});
					end
				end else begin
					next_state.partial = grown;
					next_state.seen    = seen_inc;
				end
			end else begin
				// Broken sequence: one bad point for the lead and one per
				// continuation byte already taken.
				for (int k = 0; k < 3; k++) begin
					if (2'(k) <= cur_state.seen) begin
						h = uph_pkg::absorb(h, uph_pkg::BadPoint);
					end
				end
				next_state.needed  = 2'd0;
				next_state.seen    = 2'd0;
				next_state.partial = '0;
				next_state.hash    = h;
			end
		end

		if (take_lead) begin
			if (data_byte[7] == 1'b0) begin
				if (data_byte == 8'd0) begin
					result.emit     = 1'b1;
					result.hash     = h;
					next_state.hash = '0;
				end else begin
					next_state.hash = uph_pkg::absorb(h, byte_point);
				end
			end else if (data_byte >= uph_pkg::LeadTwoLo && data_byte <= uph_pkg::LeadTwoHi) begin
				next_state.partial = {{(uph_pkg::PartialWidth-5){1'b0}}, data_byte[4:0]};
				next_state.needed  = 2'd1;
				next_state.seen    = 2'd0;
				next_state.hash    = h;
			end else if (data_byte >= uph_pkg::LeadThreeLo
					&& data_byte <= uph_pkg::LeadThreeHi) begin
				next_state.partial = {{(uph_pkg::PartialWidth-4){1'b0}}, data_byte[3:0]};
				next_state.needed  = 2'd2;
				next_state.seen    = 2'd0;
				next_state.hash    = h;
			end else if (data_byte == uph_pkg::LeadFour) begin
				next_state.partial = '0;
				next_state.needed  = 2'd3;
				next_state.seen    = 2'd0;
				next_state.hash    = h;
			end else begin
				next_state.hash = uph_pkg::absorb(h, uph_pkg::BadPoint);
			end
		end
	end

endmodule

// ----- tb/sv/utf8_path_hash_top_tb.sv -----
// ----------------------------------------------------------------------------
// utf8_path_hash_top_tb: self-checking testbench of the UTF-8 path hash
// Streams path bytes into the block under random idling on both channels,
// predicts every emitted hash with an independent decoder and hash model,
// and compares each hash word that leaves the block with the oldest one
// predicted. Directed paths cover the byte classes and the broken and
// overlong sequences; random paths, noise and a long receiver hold-off follow.
// ----------------------------------------------------------------------------
module utf8_path_hash_top_tb;

	localparam int HashWidth    = uph_pkg::HashWidth;
	localparam int PartialWidth = uph_pkg::PartialWidth;
	localparam int RotBits      = uph_pkg::RotBits;

	// Run limit in cycles, set well above the length of a correct run.
	localparam int unsigned CycleLimit   = 400000;
	localparam int unsigned RandomItems  = 400;
	localparam int unsigned DrainCycles  = 16;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 in_valid  = 1'b0;
	logic                 in_stall;
	logic [7:0]           data_byte = 8'h00;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [HashWidth-1:0] digest;

	// Predicted decoder state, a copy of what the block should hold.
	logic [HashWidth-1:0]    path_acc    = '0;
	logic [PartialWidth-1:0] dec_partial = '0;
	logic [1:0]              dec_needed  = 2'd0;
	logic [1:0]              dec_seen    = 2'd0;

	// Hashes predicted but not yet seen on the output, oldest first.
	logic [HashWidth-1:0] hash_queue[$];

	int unsigned error_count  = 0;
	int unsigned bytes_sent   = 0;
	int unsigned cycle_count  = 0;

	// Idling controls. tx_gaps and rx_stalls turn the random bursts on and
	// off; hold_cycles, when set, keeps the receiver stalled for that long.
	bit          tx_gaps       = 1'b1;
	bit          rx_stalls     = 1'b1;
	int unsigned hold_cycles   = 0;
	int unsigned rx_burst_left = 0;

	utf8_path_hash_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.data_byte (data_byte),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.digest    (digest)
	);

	always #10 clk = ~clk;

	// A hard limit on the run, so a hung handshake cannot stall it forever.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CycleLimit) begin
			$display("mismatch: run exceeded %0d cycles", CycleLimit);
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input logic [HashWidth-1:0] got,
			input logic [HashWidth-1:0] want);
		$display("mismatch at cycle %0d: %s, got %h expected %h", cycle_count, what, got, want);
		error_count++;
	endtask

	// Case fold plus one rotate-add step of the running hash.
	function automatic logic [HashWidth-1:0] mix_point(input logic [HashWidth-1:0] h,
			input logic [HashWidth-1:0] p);
		logic [HashWidth-1:0] folded;
		folded = p;
		if (p >= 32'h61 && p <= 32'h7A) begin
			folded = p - 32'h20;
		end else if (p == 32'h5C) begin
			folded = 32'h2F;
		end
		return {h[HashWidth-RotBits-1:0], h[HashWidth-1:HashWidth-RotBits]} + folded;
	endfunction

	// Advances the predicted decoder by one byte. A finished code point of
	// zero hands back the running hash and starts a new path.
	function automatic void predict_byte(input logic [7:0] b, output logic emit,
			output logic [HashWidth-1:0] hash_out);
		logic [HashWidth-1:0] cp;
		logic [1:0]           seen_next;
		logic                 have_cp;
		logic                 as_lead;
		int                   k;
		emit     = 1'b0;
		hash_out = '0;
		have_cp  = 1'b0;
		as_lead  = 1'b1;
		cp       = '0;
		if (dec_needed != 2'd0) begin
			if ((b & uph_pkg::ContMask) == uph_pkg::ContTag) begin
				as_lead     = 1'b0;
				dec_partial = {dec_partial[PartialWidth-7:0], b[5:0]};
				seen_next   = dec_seen + 2'd1;
				if (seen_next >= dec_needed) begin
					cp          = HashWidth'(dec_partial);
					have_cp     = 1'b1;
					dec_partial = '0;
					dec_needed  = 2'd0;
					dec_seen    = 2'd0;
				end else begin
					dec_seen = seen_next;
				end
			end else begin
				// The lead and every continuation taken so far each count as bad.
				for (k = 0; k <= int'(dec_seen); k++) begin
					path_acc = mix_point(path_acc, uph_pkg::BadPoint);
				end
				dec_partial = '0;
				dec_needed  = 2'd0;
				dec_seen    = 2'd0;
			end
		end
		if (as_lead) begin
			if (b < uph_pkg::ContTag) begin
				cp      = HashWidth'(b);
				have_cp = 1'b1;
			end else if (b >= uph_pkg::LeadTwoLo && b <= uph_pkg::LeadTwoHi) begin
				dec_partial = PartialWidth'(b[4:0]);
				dec_needed  = 2'd1;
				dec_seen    = 2'd0;
			end else if (b >= uph_pkg::LeadThreeLo && b <= uph_pkg::LeadThreeHi) begin
				dec_partial = PartialWidth'(b[3:0]);
				dec_needed  = 2'd2;
				dec_seen    = 2'd0;
			end else if (b == uph_pkg::LeadFour) begin
				dec_partial = '0;
				dec_needed  = 2'd3;
				dec_seen    = 2'd0;
			end else begin
				path_acc = mix_point(path_acc, uph_pkg::BadPoint);
			end
		end
		if (have_cp) begin
			if (cp == '0) begin
				emit     = 1'b1;
				hash_out = path_acc;
				path_acc = '0;
			end else begin
				path_acc = mix_point(path_acc, cp);
			end
		end
	endfunction

	// Offers one byte, optionally after a random gap, and holds it until the
	// block takes the word. The prediction is made at the accepting edge.
	task automatic send_byte(input logic [7:0] b);
		int unsigned          gap;
		logic                 emit;
		logic [HashWidth-1:0] want;
		if (tx_gaps && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 15);
			in_valid  <= 1'b0;
			data_byte <= 8'($urandom);
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		data_byte <= b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_byte(b, emit, want);
		if (emit) begin
			hash_queue.push_back(want);
		end
		bytes_sent++;
	endtask

	// Receiver: a long hold-off when one is requested, otherwise random
	// stall bursts while rx_stalls is set.
	always @(posedge clk) begin
		if (hold_cycles != 0) begin
			hold_cycles--;
			out_stall <= 1'b1;
		end else if (rx_burst_left != 0) begin
			rx_burst_left--;
			out_stall <= 1'b1;
		end else if (rx_stalls && $urandom_range(0, 3) == 0) begin
			rx_burst_left = $urandom_range(1, 15) - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Every hash word that leaves the block must match the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (hash_queue.size() == 0) begin
				report_mismatch("hash word with no path ended", digest, '0);
			end else begin
				if (digest !== hash_queue[0]) begin
					report_mismatch("digest", digest, hash_queue[0]);
				end
				void'(hash_queue.pop_front());
			end
		end
	end

	function automatic logic [7:0] pick_ascii();
		int unsigned sel;
		sel = $urandom_range(0, 9);
		if (sel < 4) begin
			return 8'($urandom_range(8'h61, 8'h7A));
		end else if (sel == 4) begin
			return 8'h5C;
		end
		return 8'($urandom_range(1, 8'h7F));
	endfunction

	function automatic logic [7:0] pick_cont();
		return uph_pkg::ContTag | 8'($urandom_range(0, 8'h3F));
	endfunction

	// Sends a lead that wants n continuation bytes.
	task automatic send_lead(input int unsigned n);
		if (n == 1) begin
			send_byte(8'($urandom_range(uph_pkg::LeadTwoLo, uph_pkg::LeadTwoHi)));
		end else if (n == 2) begin
			send_byte(8'($urandom_range(uph_pkg::LeadThreeLo, uph_pkg::LeadThreeHi)));
		end else begin
			send_byte(uph_pkg::LeadFour);
		end
	endtask

	// One path of random code points, mostly well formed, then its end.
	task automatic send_random_path();
		int unsigned n_points;
		int unsigned kind;
		int unsigned n_cont;
		int unsigned k;
		int unsigned j;
		n_points = $urandom_range(0, 10);
		for (k = 0; k < n_points; k++) begin
			kind = $urandom_range(0, 99);
			if (kind < 40) begin
				send_byte(pick_ascii());
			end else if (kind < 75) begin
				// A complete two, three or four byte sequence.
				n_cont = $urandom_range(1, 3);
				send_lead(n_cont);
				for (j = 0; j < n_cont; j++) send_byte(pick_cont());
			end else if (kind < 82) begin
				// A lead that is never valid, from either bad range.
				if ($urandom_range(0, 1) == 0) begin
					send_byte(8'($urandom_range(8'h80, 8'hC1)));
				end else begin
					send_byte(8'($urandom_range(8'hF1, 8'hFF)));
				end
			end else if (kind < 94) begin
				// A sequence cut short; the next byte breaks it.
				n_cont = $urandom_range(1, 3);
				send_lead(n_cont);
				j = $urandom_range(0, n_cont - 1);
				while (j != 0) begin
					send_byte(pick_cont());
					j--;
				end
			end else if (kind < 97) begin
				// Overlong zero, which ends the path early.
				send_byte(uph_pkg::LeadThreeLo);
				send_byte(uph_pkg::ContTag);
				send_byte(uph_pkg::ContTag);
			end else begin
				send_byte(uph_pkg::LeadFour);
				send_byte(uph_pkg::ContTag);
				send_byte(uph_pkg::ContTag);
				send_byte(uph_pkg::ContTag);
			end
		end
		if ($urandom_range(0, 7) == 0) begin
			// The terminator breaks a pending sequence.
			send_lead($urandom_range(1, 3));
		end
		send_byte(8'h00);
	endtask

	// Plain bytes: empty path, the fold of both letter ends, the backslash
	// rewrite and the top of the single-byte range.
	task automatic test_plain_bytes();
		send_byte(8'h00);
		send_byte(8'h61);
		send_byte(8'h7A);
		send_byte(8'h5C);
		send_byte(8'h7F);
		send_byte(8'h00);
	endtask

	// Multibyte code points at the range ends, and both overlong zeros.
	task automatic test_multibyte_points();
		send_byte(uph_pkg::LeadTwoLo);
		send_byte(uph_pkg::ContTag);
		send_byte(uph_pkg::LeadThreeHi);
		send_byte(8'hBF);
		send_byte(8'hBF);
		send_byte(uph_pkg::LeadThreeLo);
		send_byte(uph_pkg::ContTag);
		send_byte(uph_pkg::ContTag);
		send_byte(uph_pkg::LeadFour);
		send_byte(uph_pkg::ContTag);
		send_byte(uph_pkg::ContTag);
		send_byte(uph_pkg::ContTag);
	endtask

	// Invalid leads at both ends, a sequence broken by a letter, and a
	// zero byte breaking a nearly complete four byte sequence.
	task automatic test_invalid_and_broken();
		send_byte(uph_pkg::ContTag);
		send_byte(8'hFF);
		send_byte(uph_pkg::LeadThreeLo);
		send_byte(uph_pkg::ContTag);
		send_byte(8'h41);
		send_byte(uph_pkg::LeadFour);
		send_byte(uph_pkg::ContTag);
		send_byte(uph_pkg::ContTag);
		send_byte(8'h00);
	endtask

	// Random paths and noise, with idling switched on and off now and then
	// so that quiet stretches mix with heavy gaps and stalls.
	task automatic test_random_paths();
		int unsigned stop_at;
		int unsigned n_noise;
		stop_at = bytes_sent + RandomItems;
		while (bytes_sent < stop_at) begin
			if ($urandom_range(0, 7) == 0) begin
				tx_gaps   = 1'($urandom_range(0, 1));
				rx_stalls = 1'($urandom_range(0, 1));
			end
			if ($urandom_range(0, 9) == 0) begin
				n_noise = $urandom_range(1, 8);
				repeat (n_noise) send_byte(8'($urandom_range(0, 255)));
			end else begin
				send_random_path();
			end
		end
		tx_gaps   = 1'b1;
		rx_stalls = 1'b1;
	endtask

	// The receiver holds off for a long stretch while the sender keeps
	// offering short paths, so hashes back up and the input stalls.
	task automatic test_output_hold_off();
		int unsigned k;
		tx_gaps     = 1'b0;
		hold_cycles = 150;
		for (k = 0; k < 12; k++) begin
			send_byte(pick_ascii());
			send_byte(8'h00);
		end
		tx_gaps = 1'b1;
	endtask

	// Closing stretch with no idling on either side.
	task automatic test_no_idle_tail();
		int unsigned k;
		tx_gaps       = 1'b0;
		rx_stalls     = 1'b0;
		rx_burst_left = 0;
		for (k = 0; k < 8; k++) send_random_path();
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_plain_bytes();
		test_multibyte_points();
		test_invalid_and_broken();
		test_random_paths();
		test_output_hold_off();
		test_no_idle_tail();

		in_valid <= 1'b0;
		while (hash_queue.size() != 0) @(posedge clk);
		// Wait DrainCycles more so that any stray hash word would show.
		repeat (DrainCycles) @(posedge clk);
		if (hash_queue.size() != 0) begin
			report_mismatch("hash never emitted", '0, hash_queue[0]);
		end
		if (error_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+design
design/uph_pkg.sv
design/uph_step.sv
design/utf8_path_hash_top.sv
tb/sv/utf8_path_hash_top_tb.sv
